@@ src/skt_pkg.sv @@
package skt_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUPLICATE = 2'd3;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// fixed field widths
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	typedef struct packed {
		logic                load;    // capture accepted item
		logic                rd_mid;  // read middle entry of search range
		logic                step;    // narrow search range
		logic                rd_lo;   // read entry at lower bound
		logic                shift;   // move one entry up one slot
		logic                place;   // write new pair at lower bound
		logic                post;    // load result register
		logic [STATUS_W-1:0] code;    // status for post
	} skt_cmd_t;

	typedef struct packed {
		logic lt_hi;       // search range not empty
		logic key_lt;      // read key below item key
		logic hit;         // entry at lower bound holds item key
		logic full;        // table at capacity
		logic idx_gt_pos;  // entries left to shift
		logic lookup;      // item is a lookup
		logic out_free;    // result register can take a result
	} skt_sts_t;

endpackage

@@ src/skt_if.sv @@
interface skt_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [skt_pkg::KEY_W-1:0]    key;
	logic [skt_pkg::HANDLE_W-1:0] handle;

	modport source (output valid, action, key, handle, input ready);
	modport sink (input valid, action, key, handle, output ready);
endinterface

interface skt_out_if;
	logic                         valid;
	logic                         ready;
	logic [skt_pkg::STATUS_W-1:0] status;
	logic [skt_pkg::HANDLE_W-1:0] found_handle;
	logic [skt_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, status, found_handle, entry_count, input ready);
	modport sink (input valid, status, found_handle, entry_count, output ready);
endinterface

@@ src/skt_ctrl.sv @@
module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  skt_pkg::skt_sts_t sts,
	output logic              idle,
	output skt_pkg::skt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SEARCH  = 3'd1;
	localparam logic [2:0] S_COMPARE = 3'd2;
	localparam logic [2:0] S_CHECK   = 3'd3;
	localparam logic [2:0] S_SHIFT   = 3'd4;
	localparam logic [2:0] S_PLACE   = 3'd5;
	localparam logic [2:0] S_POST    = 3'd6;

	logic [2:0]                   state_q, state_d;
	logic [skt_pkg::STATUS_W-1:0] code_q, code_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_d    = S_COMPARE;
				end else begin
					cmd.rd_lo = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_COMPARE: begin
				cmd.step = 1'b1;
				state_d  = S_SEARCH;
			end
			S_CHECK: begin
				// full check ranks ahead of the duplicate check
				priority if (sts.lookup) begin
					code_d  = sts.hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
					state_d = S_POST;
				end else if (sts.full) begin
					code_d  = skt_pkg::ST_FULL;
					state_d = S_POST;
				end else if (sts.hit) begin
					code_d  = skt_pkg::ST_DUPLICATE;
					state_d = S_POST;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// last pending write lands on the edge that leaves this state
				if (sts.idx_gt_pos) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				code_d    = skt_pkg::ST_OK;
				state_d   = S_POST;
			end
			S_POST: begin
				if (sts.out_free) begin
					cmd.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= skt_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

@@ src/skt_datapath.sv @@
module skt_datapath #(
	parameter int CAPACITY    = 256,
	parameter int KEY_BYTES   = 8,
	parameter int HANDLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	skt_in_if.sink            req,
	skt_out_if.source         rsp,
	input  skt_pkg::skt_cmd_t cmd,
	output skt_pkg::skt_sts_t sts
);

	localparam int KW = 8 * KEY_BYTES;
	localparam int HW = (HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS : skt_pkg::HANDLE_W;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// keep the first KEY_BYTES bytes, zero everything after the first zero byte
	function automatic logic [KW-1:0] norm_key(input logic [skt_pkg::KEY_W-1:0] k);
		logic [KW-1:0] r;
		logic          stop;
		r    = k[skt_pkg::KEY_W-1 -: KW];
		stop = 1'b0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (r[KW-1-8*b -: 8] == 8'd0) begin
				stop = 1'b1;
			end
			if (stop) begin
				r[KW-1-8*b -: 8] = 8'd0;
			end
		end
		return r;
	endfunction

	logic [KW-1:0] keys_mem [CAPACITY];
	logic [HW-1:0] hdls_mem [CAPACITY];

	logic [KW-1:0] key_q;
	logic [HW-1:0] hdl_q;
	logic          act_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, mid_q, idx_q;
	logic [AW-1:0] wr_addr_q;
	logic          wr_pend_q;
	logic [KW-1:0] rd_key_q;
	logic [HW-1:0] rd_hdl_q;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [KW-1:0] wr_key;
	logic [HW-1:0] wr_hdl;
	logic [CW-1:0] mid;
	logic [CW-1:0] idx_m1;

	logic                         out_valid_q;
	logic [skt_pkg::STATUS_W-1:0] out_status_q;
	logic [skt_pkg::HANDLE_W-1:0] out_found_q;
	logic [skt_pkg::COUNT_W-1:0]  out_count_q;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1 = idx_q - CW'(1);

	always_comb begin
		rd_en   = cmd.rd_mid | cmd.rd_lo | cmd.shift;
		rd_addr = lo_q[AW-1:0];
		if (cmd.rd_mid) begin
			rd_addr = mid[AW-1:0];
		end else if (cmd.shift) begin
			rd_addr = idx_m1[AW-1:0];
		end
		wr_en   = wr_pend_q | cmd.place;
		wr_addr = cmd.place ? lo_q[AW-1:0] : wr_addr_q;
		wr_key  = cmd.place ? key_q : rd_key_q;
		wr_hdl  = cmd.place ? hdl_q : rd_hdl_q;
	end

	// single-port-write, single-port-read table with registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= keys_mem[rd_addr];
			rd_hdl_q <= hdls_mem[rd_addr];
		end
		if (wr_en) begin
			keys_mem[wr_addr] <= wr_key;
			hdls_mem[wr_addr] <= wr_hdl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= norm_key(req.key);
			hdl_q <= req.handle[HW-1:0];
			act_q <= req.action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			idx_q     <= '0;
			wr_addr_q <= '0;
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= cmd.shift;
			if (cmd.load) begin
				lo_q  <= '0;
				hi_q  <= cnt_q;
				idx_q <= cnt_q;
			end
			if (cmd.rd_mid) begin
				mid_q <= mid;
			end
			if (cmd.step) begin
				if (sts.key_lt) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			if (cmd.shift) begin
				idx_q     <= idx_m1;
				wr_addr_q <= idx_q[AW-1:0];
			end
			if (cmd.place) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_status_q <= cmd.code;
			out_count_q  <= skt_pkg::COUNT_W'(cnt_q);
			if (act_q == skt_pkg::ACT_LOOKUP && cmd.code == skt_pkg::ST_OK) begin
				out_found_q <= skt_pkg::HANDLE_W'(rd_hdl_q);
			end else begin
				out_found_q <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found_handle = out_found_q;
	assign rsp.entry_count  = out_count_q;

	always_comb begin
		sts.lt_hi      = (lo_q < hi_q);
		sts.key_lt     = (rd_key_q < key_q);
		sts.hit        = (lo_q < cnt_q) && (rd_key_q == key_q);
		sts.full       = (cnt_q == CW'(CAPACITY));
		sts.idx_gt_pos = (idx_q > lo_q);
		sts.lookup     = (act_q == skt_pkg::ACT_LOOKUP);
		sts.out_free   = !out_valid_q || rsp.ready;
	end

endmodule

@@ src/sorted_key_table_insert_lookup.sv @@
// Sorted key table: holds up to CAPACITY key/handle pairs in ascending key order.
// req channel (valid/ready): action (0 insert, 1 lookup), key, handle. Keys are
//   names packed first byte high; bytes past KEY_BYTES or after the first zero
//   byte are treated as zero. Handles keep their low HANDLE_BITS bits.
// rsp channel (valid/ready): status (ok/found, not found, full, duplicate),
//   found_handle (lookups only, else zero), entry_count after the item.
// One transfer in gives exactly one transfer out. Items are handled one at a
// time; req.ready is high only while the controller is idle.
// Binary search: each halving step is a registered memory read then a compare,
// followed by a final read at the lower bound and the decision.
// An insert then shifts each larger entry up one slot, drains the last write,
// places the pair and posts the result. The worst case is set by the one
// write port of the table memory during the shift.
// Results sit in an output register; a new item is taken while it waits, but
// the next result is held back until rsp.ready frees that register.
// Reset (arst_n low) empties the table; memory contents are not cleared.
module sorted_key_table_insert_lookup #(
	parameter int CAPACITY    = 256,
	parameter int KEY_BYTES   = 8,
	parameter int HANDLE_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	skt_in_if.sink    req,
	skt_out_if.source rsp
);

	skt_pkg::skt_cmd_t cmd;
	skt_pkg::skt_sts_t sts;
	logic              idle;
	logic              in_fire;

	// accept only while no item is in flight
	assign req.ready = idle;
	assign in_fire   = req.valid & idle;

	skt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.sts     (sts),
		.idle    (idle),
		.cmd     (cmd)
	);

	skt_datapath #(
		.CAPACITY    (CAPACITY),
		.KEY_BYTES   (KEY_BYTES),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

@@ dv/sorted_key_table_insert_lookup_tb.sv @@
module sorted_key_table_insert_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY    = 256;
	localparam int KEY_BYTES   = 8;
	localparam int HANDLE_BITS = 16;

	localparam logic [skt_pkg::HANDLE_W-1:0] HANDLE_MASK =
		(HANDLE_BITS >= skt_pkg::HANDLE_W) ? {skt_pkg::HANDLE_W{1'b1}} :
		skt_pkg::HANDLE_W'((32'd1 << HANDLE_BITS) - 1);

	// worst insert: full shift plus search and posting, with margin
	localparam int LATENCY_CYCLES = CAPACITY + 40;
	// receiver hold-off used to back the block up into its input
	localparam int HOLD_CYCLES    = 400;
	localparam int ITEM_TARGET    = 1350;

	typedef struct packed {
		logic [skt_pkg::STATUS_W-1:0] status;
		logic [skt_pkg::HANDLE_W-1:0] found_handle;
		logic [skt_pkg::COUNT_W-1:0]  entry_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	skt_in_if  req_ch ();
	skt_out_if rsp_ch ();

	sorted_key_table_insert_lookup #(
		.CAPACITY   (CAPACITY),
		.KEY_BYTES  (KEY_BYTES),
		.HANDLE_BITS(HANDLE_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #5 clk = ~clk;

	// Shadow of the table as the block should hold it, updated at each
	// accepted transfer. Keys are kept in canonical form, ascending.
	logic [skt_pkg::KEY_W-1:0]    table_keys [CAPACITY];
	logic [skt_pkg::HANDLE_W-1:0] table_handles [CAPACITY];
	int                           table_used;

	table_result_t expected_results [$];

	int error_count;
	int n_insert;
	int n_lookup;
	int n_results;
	int status_seen [4];

	// test -> receiver controls; the receiver process only reads these
	bit no_idle;
	bit hold_req;

	// receiver-owned state
	bit hold_seen;
	int hold_left;
	int ready_left;

	task automatic report_error(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Only the first KEY_BYTES bytes count, and a zero byte ends the name:
	// everything past the terminator reads as zero.
	function automatic logic [skt_pkg::KEY_W-1:0] canon_key(
			input logic [skt_pkg::KEY_W-1:0] raw);
		logic [skt_pkg::KEY_W-1:0] k;
		logic [7:0]                b;
		bit                        ended;
		int                        n;
		k = '0;
		ended = 1'b0;
		for (n = 0; n < 8; n++) begin
			b = raw[63-8*n -: 8];
			if (n >= KEY_BYTES || b == 8'h00)
				ended = 1'b1;
			if (!ended)
				k[63-8*n -: 8] = b;
		end
		return k;
	endfunction

	// Apply one transfer to the shadow table and return the result it owes.
	function automatic table_result_t table_apply(input logic act,
			input logic [skt_pkg::KEY_W-1:0] raw,
			input logic [skt_pkg::HANDLE_W-1:0] hdl);
		table_result_t             r;
		logic [skt_pkg::KEY_W-1:0] k;
		int                        slot;
		int                        i;
		k = canon_key(raw);
		slot = 0;
		// first slot whose key is not below k
		while (slot < table_used && table_keys[slot] < k)
			slot++;
		r.found_handle = '0;
		if (act == skt_pkg::ACT_INSERT) begin
			if (table_used >= CAPACITY) begin
				r.status = skt_pkg::ST_FULL;  // full wins over duplicate
			end else if (slot < table_used && table_keys[slot] == k) begin
				r.status = skt_pkg::ST_DUPLICATE;
			end else begin
				for (i = table_used; i > slot; i--) begin
					table_keys[i]    = table_keys[i-1];
					table_handles[i] = table_handles[i-1];
				end
				table_keys[slot]    = k;
				table_handles[slot] = hdl & HANDLE_MASK;
				table_used++;
				r.status = skt_pkg::ST_OK;
			end
		end else begin
			if (slot < table_used && table_keys[slot] == k) begin
				r.status       = skt_pkg::ST_OK;
				r.found_handle = table_handles[slot];
			end else begin
				r.status = skt_pkg::ST_NOT_FOUND;
			end
		end
		r.entry_count = skt_pkg::COUNT_W'(table_used);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// key generators
	// ---------------------------------------------------------------
	function automatic logic [skt_pkg::KEY_W-1:0] make_name(input int len, input int lo,
			input int hi);
		logic [skt_pkg::KEY_W-1:0] k;
		int                        n;
		k = '0;
		for (n = 0; n < len && n < 8; n++)
			k[63-8*n -: 8] = 8'($urandom_range(lo, hi));
		return k;
	endfunction

	// Fill the bytes past the terminator with junk; the name stays the same.
	function automatic logic [skt_pkg::KEY_W-1:0] smear_tail(
			input logic [skt_pkg::KEY_W-1:0] k);
		logic [skt_pkg::KEY_W-1:0] out;
		bit                        ended;
		int                        n;
		out = k;
		ended = 1'b0;
		for (n = 0; n < 8; n++) begin
			if (ended)
				out[63-8*n -: 8] = 8'($urandom);
			else if (k[63-8*n -: 8] == 8'h00)
				ended = 1'b1;
		end
		return out;
	endfunction

	function automatic logic [skt_pkg::KEY_W-1:0] stored_key();
		if (table_used == 0)
			return make_name($urandom_range(1, 8), 8'h21, 8'h7e);
		return table_keys[$urandom_range(0, table_used - 1)];
	endfunction

	function automatic logic [skt_pkg::KEY_W-1:0] corner_key();
		case ($urandom_range(0, 4))
			0: return '0;                        // empty name
			1: return '1;
			2: return 64'h0100_0000_0000_0000;   // lowest nonempty name
			3: return 64'h8000_0000_0000_0000;
			default: return 64'hFFFF_FFFF_FFFF_FFFE;
		endcase
	endfunction

	// Mostly plausible names, a fair share of repeats and near neighbors so
	// that duplicates and close misses show up, plus raw noise.
	function automatic logic [skt_pkg::KEY_W-1:0] pick_key(input logic act);
		int r;
		r = $urandom_range(0, 99);
		if (act == skt_pkg::ACT_INSERT) begin
			if (r < 45) return make_name($urandom_range(1, 8), 8'h21, 8'h7e);
			if (r < 60) return make_name($urandom_range(1, 3), 8'h61, 8'h64);
			if (r < 75) return ($urandom_range(0, 1)) ? smear_tail(stored_key()) : stored_key();
			if (r < 92) return {$urandom, $urandom};
			return corner_key();
		end
		if (r < 45) return ($urandom_range(0, 1)) ? smear_tail(stored_key()) : stored_key();
		if (r < 65) return make_name($urandom_range(1, 3), 8'h61, 8'h64);
		if (r < 80) return ($urandom_range(0, 1)) ? stored_key() + 64'd1 : stored_key() - 64'd1;
		if (r < 93) return {$urandom, $urandom};
		return corner_key();
	endfunction

	function automatic int sender_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------
	// Called at a rising edge. Holds the item until the transfer, records
	// the owed result, then idles for a random gap. With no gap, valid is
	// left high only because the caller offers the next item in this step.
	task automatic send_request(input logic act, input logic [skt_pkg::KEY_W-1:0] key,
			input logic [skt_pkg::HANDLE_W-1:0] hdl);
		int gap;
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.key    <= key;
		req_ch.handle <= hdl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_results.push_back(table_apply(act, key, hdl));
		if (act == skt_pkg::ACT_INSERT)
			n_insert++;
		else
			n_lookup++;
		gap = sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic act;
		act = ($urandom_range(0, 99) < (table_used < CAPACITY ? 55 : 35)) ?
			skt_pkg::ACT_INSERT : skt_pkg::ACT_LOOKUP;
		send_request(act, pick_key(act), skt_pkg::HANDLE_W'($urandom));
	endtask

	// Sender pause: nothing offered until every owed result has come back.
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// response side: ready pattern with its own stall counting
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (no_idle) begin
			rsp_ch.ready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			// mostly ready, short stalls, now and then a long one
			case ($urandom_range(0, 19))
				0: begin
					rsp_ch.ready <= 1'b0;
					ready_left   <= $urandom_range(20, 90);
				end
				1, 2, 3, 4: begin
					rsp_ch.ready <= 1'b0;
					ready_left   <= $urandom_range(1, 4);
				end
				default: begin
					rsp_ch.ready <= 1'b1;
					ready_left   <= $urandom_range(1, 24);
				end
			endcase
		end
	end

	// Each result transfer is matched against the oldest owed result.
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_error($sformatf("result with nothing owed: status %0d count %0d",
					rsp_ch.status, rsp_ch.entry_count));
			end else begin
				want = expected_results.pop_front();
				n_results++;
				status_seen[want.status]++;
				if (rsp_ch.status !== want.status)
					report_error($sformatf("status got %0d want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.found_handle !== want.found_handle)
					report_error($sformatf("found_handle got %h want %h",
						rsp_ch.found_handle, want.found_handle));
				if (rsp_ch.entry_count !== want.entry_count)
					report_error($sformatf("entry_count got %0d want %0d",
						rsp_ch.entry_count, want.entry_count));
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// Corners on a small table: empty name, all-ones key, junk after the
	// terminator on both inserts and lookups, prefixes ordering below longer
	// names, handle extremes, handle field ignored on lookups.
	task automatic test_directed();
		send_request(skt_pkg::ACT_LOOKUP, 64'h6162_6300_0000_0000, 16'hFFFF);  // "abc", empty
		send_request(skt_pkg::ACT_INSERT, 64'h0000_0000_0000_0000, 16'hFFFF);  // empty name
		send_request(skt_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		send_request(skt_pkg::ACT_INSERT, 64'h6162_6300_0000_0000, 16'h1234);  // "abc"
		send_request(skt_pkg::ACT_INSERT, 64'h6162_6300_DEAD_BEEF, 16'h4321);  // junk tail
		send_request(skt_pkg::ACT_LOOKUP, 64'h6162_6300_5555_AAAA, 16'hFFFF);
		send_request(skt_pkg::ACT_LOOKUP, 64'h6162_0000_0000_0000, 16'h0000);  // "ab" absent
		send_request(skt_pkg::ACT_INSERT, 64'h6162_0000_0000_0000, 16'h00FF);
		send_request(skt_pkg::ACT_INSERT, 64'h6162_6364_0000_0000, 16'hFF00);  // "abcd"
		send_request(skt_pkg::ACT_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 16'h0000);  // empty name
		send_request(skt_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hAAAA);
		send_request(skt_pkg::ACT_INSERT, 64'h0012_3456_789A_BCDE, 16'h5555);  // empty again
		send_request(skt_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
		send_request(skt_pkg::ACT_INSERT, 64'h0100_0000_0000_0000, 16'h0001);
		send_request(skt_pkg::ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF);
		send_request(skt_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0001, 16'h0000);  // tail after 80 00
		send_request(skt_pkg::ACT_LOOKUP, 64'h6162_6364_0000_0000, 16'h0000);
		send_request(skt_pkg::ACT_LOOKUP, 64'h6162_6364_6500_0000, 16'h0000);  // "abcde" absent
		send_request(skt_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 16'hA5A5);
		send_request(skt_pkg::ACT_LOOKUP, 64'h0100_0000_0000_0000, 16'hFFFF);
		wait_all_results();
	endtask

	// Receiver holds off while the sender keeps offering: the result
	// register fills, the block parks a finished item and stops taking more.
	task automatic test_backpressure();
		int n;
		no_idle  = 1'b1;
		hold_req = ~hold_req;
		for (n = 0; n < 8; n++)
			send_random();
		no_idle = 1'b0;
		wait_all_results();
	endtask

	// Random traffic until the table holds CAPACITY entries.
	task automatic test_fill();
		while (table_used < CAPACITY)
			send_random();
		wait_all_results();
	endtask

	task automatic test_full_table();
		// full beats duplicate
		send_request(skt_pkg::ACT_INSERT, table_keys[0], skt_pkg::HANDLE_W'($urandom));
		send_request(skt_pkg::ACT_INSERT, smear_tail(table_keys[CAPACITY-1]), 16'hFFFF);
		send_request(skt_pkg::ACT_INSERT, make_name(5, 8'h21, 8'h7e), 16'h0000);
		send_request(skt_pkg::ACT_LOOKUP, table_keys[0], 16'h0000);
		send_request(skt_pkg::ACT_LOOKUP, smear_tail(table_keys[CAPACITY-1]), 16'hFFFF);
		send_request(skt_pkg::ACT_LOOKUP, table_keys[CAPACITY/2] + 64'd1, 16'h0000);
		wait_all_results();
	endtask

	// Mixed traffic on the full table; opens with a stretch of no idling.
	task automatic test_random_mix();
		int n;
		no_idle = 1'b1;
		for (n = 0; n < 150; n++)
			send_random();
		no_idle = 1'b0;
		while (n_insert + n_lookup < ITEM_TARGET)
			send_random();
		wait_all_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.action = skt_pkg::ACT_INSERT;
		req_ch.key    = '0;
		req_ch.handle = '0;
		table_used    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_fill();
		test_full_table();
		test_random_mix();

		// let a stray late result show itself
		repeat (LATENCY_CYCLES) @(posedge clk);

		$display("covered %0d transfers in (%0d inserts, %0d lookups), %0d results checked",
			n_insert + n_lookup, n_insert, n_lookup, n_results);
		$display("status mix: ok %0d, not found %0d, full %0d, duplicate %0d; table size %0d",
			status_seen[skt_pkg::ST_OK], status_seen[skt_pkg::ST_NOT_FOUND],
			status_seen[skt_pkg::ST_FULL], status_seen[skt_pkg::ST_DUPLICATE], table_used);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Slowest correct run, with every item at its worst block time, sender gap
	// and receiver stall, is about 6 ms; allow five times that.
	initial begin
		#30_000_000;
		$display("timeout: %0d results still owed", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
